>>> rtl/core/mft_pkg.sv
`timescale 1ns / 1ps

package mft_pkg;

  localparam int ID_W       = 11;
  localparam int ANG_W      = 16;
  localparam int SPD_W      = 16;
  localparam int TRQ_W      = 16;
  localparam int TEMP_W     = 8;
  localparam int SLOT_W     = 4;
  localparam int MASK_W     = 8;
  localparam int TURN_OUT_W = 24;
  localparam int TOTAL_W    = 41;

  localparam logic [ID_W-1:0] SLOT_BASE = 11'h200;

  localparam logic signed [ANG_W-1:0] RAW_FULL    = 16'sd8191;
  localparam logic signed [ANG_W-1:0] TOP_LOW     = 16'sd6144;
  localparam logic signed [ANG_W-1:0] BOTTOM_HIGH = 16'sd2047;
  localparam logic signed [ANG_W-1:0] BOTTOM_LOW  = 16'sd0;

  localparam logic [16:0] Q8_PER_TURN = 17'd92160;
  localparam logic [13:0] DIVISOR     = 14'd8191;

  // floor(2^45 / 8191); quotient estimate is exact or one low for 32-bit dividends
  localparam logic [63:0] RECIP_FULL = 64'd35184372088832 / 64'd8191;
  localparam logic [32:0] RECIP      = RECIP_FULL[32:0];
  localparam int          RECIP_SH   = 45;

  localparam int FIFO_DEPTH = 8;

  typedef struct packed {
    logic                     err;
    logic [SLOT_W-1:0]        slot;
    logic signed [ANG_W-1:0]  raw;
    logic signed [SPD_W-1:0]  speed;
    logic signed [TRQ_W-1:0]  torque;
    logic signed [TEMP_W-1:0] temp;
  } mft_item_t;

  typedef struct packed {
    logic                         id_error;
    logic [SLOT_W-1:0]            slot_index;
    logic signed [ANG_W-1:0]      raw_angle;
    logic signed [SPD_W-1:0]      speed_value;
    logic signed [TRQ_W-1:0]      torque_value;
    logic signed [TEMP_W-1:0]     temperature;
    logic signed [TURN_OUT_W-1:0] turn_count;
    logic signed [TOTAL_W-1:0]    total_angle_q8;
  } mft_result_t;

endpackage

>>> rtl/core/mft_if.sv
`timescale 1ns / 1ps

interface mft_fb_if import mft_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ID_W-1:0]          frame_id;
  logic [ANG_W-1:0]         angle_word;
  logic signed [SPD_W-1:0]  speed_word;
  logic signed [TRQ_W-1:0]  torque_word;
  logic signed [TEMP_W-1:0] temp_byte;

  modport source (output valid, frame_id, angle_word, speed_word, torque_word, temp_byte,
                  input ready);
  modport sink (input valid, frame_id, angle_word, speed_word, torque_word, temp_byte,
                output ready);
endinterface

interface mft_res_if import mft_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         id_error;
  logic [SLOT_W-1:0]            slot_index;
  logic signed [ANG_W-1:0]      raw_angle;
  logic signed [SPD_W-1:0]      speed_value;
  logic signed [TRQ_W-1:0]      torque_value;
  logic signed [TEMP_W-1:0]     temperature;
  logic signed [TURN_OUT_W-1:0] turn_count;
  logic signed [TOTAL_W-1:0]    total_angle_q8;

  modport source (output valid, id_error, slot_index, raw_angle, speed_value, torque_value,
                  temperature, turn_count, total_angle_q8, input ready);
  modport sink (input valid, id_error, slot_index, raw_angle, speed_value, torque_value,
                temperature, turn_count, total_angle_q8, output ready);
endinterface

>>> rtl/core/mft_ram.sv
`timescale 1ns / 1ps

module mft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/mft_update.sv
`timescale 1ns / 1ps

module mft_update import mft_pkg::*; #(
  parameter int SLOT_COUNT = 8,
  parameter int TURN_BITS  = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [ID_W-1:0]             frame_id,
  input  logic [ANG_W-1:0]            angle_word,
  input  logic signed [SPD_W-1:0]     speed_word,
  input  logic signed [TRQ_W-1:0]     torque_word,
  input  logic signed [TEMP_W-1:0]    temp_byte,
  input  logic [MASK_W-1:0]           no_temp_slot_mask,
  output logic                        upd_valid,
  output mft_item_t                   upd_item,
  output logic signed [TURN_BITS-1:0] upd_turns
);

  localparam int KW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int RW = ANG_W + TURN_BITS + TEMP_W;
  localparam logic [ID_W-1:0] ID_FIRST = SLOT_BASE + 11'd1;
  localparam logic [ID_W-1:0] ID_LAST  = SLOT_BASE + ID_W'(SLOT_COUNT);
  localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
  localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [ANG_W-1:0]     angle;
    logic signed [TURN_BITS-1:0] turns;
    logic signed [TEMP_W-1:0]    temp;
  } rec_t;

  logic [ID_W-1:0] id_off;
  logic            id_ok;
  logic            notemp0;
  logic [KW-1:0]   k0;

  logic                     s1_valid;
  logic                     s1_err;
  logic [KW-1:0]            s1_k;
  logic                     s1_notemp;
  logic [SLOT_W-1:0]        s1_slot;
  logic signed [ANG_W-1:0]  s1_angle;
  logic signed [SPD_W-1:0]  s1_speed;
  logic signed [TRQ_W-1:0]  s1_torque;
  logic signed [TEMP_W-1:0] s1_temp;
  logic                     s1_fwd;
  rec_t                     s1_fwd_rec;
  logic                     s1_hit_valid;

  logic [SLOT_COUNT-1:0] entry_valid;
  logic [RW-1:0]         rd_data;
  rec_t                  rd_rec;
  rec_t                  cur;
  rec_t                  wr_rec;
  logic                  wr_en;
  logic                  last_top;
  logic                  last_bot;
  logic                  raw_top;
  logic                  raw_bot;
  logic signed [TURN_BITS-1:0] turns_next;

  assign id_off  = frame_id - ID_FIRST;
  assign id_ok   = (frame_id >= ID_FIRST) && (frame_id <= ID_LAST);
  assign k0      = id_off[KW-1:0];
  assign notemp0 = (id_off[ID_W-1:3] == '0) && no_temp_slot_mask[id_off[2:0]];

  mft_ram #(
    .WIDTH (RW),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_k),
    .wdata (wr_rec),
    .re    (accept),
    .raddr (k0),
    .rdata (rd_data)
  );

  assign rd_rec = rec_t'(rd_data);

  // bypass the entry written by the previous frame
  always_comb begin
    if (s1_fwd) begin
      cur = s1_fwd_rec;
    end else if (s1_hit_valid) begin
      cur = rd_rec;
    end else begin
      cur = '0;
    end
  end

  assign last_top = (cur.angle >= TOP_LOW) && (cur.angle <= RAW_FULL);
  assign last_bot = (cur.angle >= BOTTOM_LOW) && (cur.angle <= BOTTOM_HIGH);
  assign raw_top  = (s1_angle >= TOP_LOW) && (s1_angle <= RAW_FULL);
  assign raw_bot  = (s1_angle >= BOTTOM_LOW) && (s1_angle <= BOTTOM_HIGH);

  always_comb begin
    turns_next = cur.turns;
    if (last_top && raw_bot) begin
      if (cur.turns != TURN_MAX) begin
        turns_next = cur.turns + TURN_BITS'(1);
      end
    end else if (last_bot && raw_top) begin
      if (cur.turns != TURN_MIN) begin
        turns_next = cur.turns - TURN_BITS'(1);
      end
    end
  end

  assign wr_en        = s1_valid && !s1_err;
  assign wr_rec.angle = s1_angle;
  assign wr_rec.turns = turns_next;
  assign wr_rec.temp  = s1_notemp ? cur.temp : s1_temp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      upd_valid   <= 1'b0;
      entry_valid <= '0;
    end else begin
      s1_valid  <= accept;
      upd_valid <= s1_valid;
      if (wr_en) begin
        entry_valid[s1_k] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_err       <= !id_ok;
      s1_k         <= k0;
      s1_notemp    <= notemp0;
      s1_slot      <= frame_id[SLOT_W-1:0];
      s1_angle     <= $signed(angle_word);
      s1_speed     <= speed_word;
      s1_torque    <= torque_word;
      s1_temp      <= temp_byte;
      s1_fwd       <= wr_en && (s1_k == k0);
      s1_fwd_rec   <= wr_rec;
      s1_hit_valid <= entry_valid[k0];
    end
    upd_item.err    <= s1_err;
    upd_item.slot   <= s1_slot;
    upd_item.raw    <= s1_angle;
    upd_item.speed  <= s1_speed;
    upd_item.torque <= s1_torque;
    upd_item.temp   <= wr_rec.temp;
    upd_turns       <= turns_next;
  end

endmodule

>>> rtl/core/mft_scale.sv
`timescale 1ns / 1ps

module mft_scale import mft_pkg::*; #(
  parameter int TURN_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        upd_valid,
  input  mft_item_t                   upd_item,
  input  logic signed [TURN_BITS-1:0] upd_turns,
  output logic                        res_valid,
  output mft_result_t                 res_data
);

  localparam int TQ_W  = TURN_BITS + 18;
  localparam int TOT_W = (TURN_BITS + 19 > TOTAL_W) ? TURN_BITS + 19 : TOTAL_W;

  logic signed [16:0] raw_ext;
  logic [16:0]        mag;
  logic [33:0]        mag_prod;
  logic signed [TQ_W-1:0] turn_prod;

  logic                        b_valid;
  mft_item_t                   b_item;
  logic signed [TURN_BITS-1:0] b_turns;
  logic [31:0]                 b_x;
  logic signed [TQ_W-1:0]      b_tq;

  logic [64:0] recip_prod;

  logic                        c_valid;
  mft_item_t                   c_item;
  logic signed [TURN_BITS-1:0] c_turns;
  logic [31:0]                 c_x;
  logic signed [TQ_W-1:0]      c_tq;
  logic [19:0]                 c_qest;

  logic [33:0] rem;
  logic [19:0] q_fix;

  logic                        d_valid;
  mft_item_t                   d_item;
  logic signed [TURN_BITS-1:0] d_turns;
  logic signed [TQ_W-1:0]      d_tq;
  logic signed [20:0]          d_q;

  logic signed [TOT_W-1:0] total;
  logic signed [31:0]      turns32;

  assign raw_ext   = {upd_item.raw[ANG_W-1], upd_item.raw};
  assign mag       = raw_ext[16] ? 17'(-raw_ext) : 17'(raw_ext);
  assign mag_prod  = mag * Q8_PER_TURN;
  assign turn_prod = upd_turns * $signed({1'b0, Q8_PER_TURN});

  assign recip_prod = b_x * RECIP;

  // remainder check; the estimate is never above the true quotient
  assign rem   = {2'b00, c_x} - {1'b0, c_qest, 13'b0} + {14'b0, c_qest};
  assign q_fix = (rem >= {20'b0, DIVISOR}) ? c_qest + 20'd1 : c_qest;

  assign total   = TOT_W'(d_tq) + TOT_W'(d_q);
  assign turns32 = 32'(d_turns);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      b_valid   <= upd_valid;
      c_valid   <= b_valid;
      d_valid   <= c_valid;
      res_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_item  <= upd_item;
    b_turns <= upd_turns;
    b_x     <= mag_prod[31:0];
    b_tq    <= turn_prod;

    c_item  <= b_item;
    c_turns <= b_turns;
    c_x     <= b_x;
    c_tq    <= b_tq;
    c_qest  <= recip_prod[64:RECIP_SH];

    d_item  <= c_item;
    d_turns <= c_turns;
    d_tq    <= c_tq;
    d_q     <= c_item.raw[ANG_W-1] ? -$signed({1'b0, q_fix}) : $signed({1'b0, q_fix});

    if (d_item.err) begin
      res_data <= {1'b1, {($bits(mft_result_t) - 1){1'b0}}};
    end else begin
      res_data.id_error       <= 1'b0;
      res_data.slot_index     <= d_item.slot;
      res_data.raw_angle      <= d_item.raw;
      res_data.speed_value    <= d_item.speed;
      res_data.torque_value   <= d_item.torque;
      res_data.temperature    <= d_item.temp;
      res_data.turn_count     <= turns32[TURN_OUT_W-1:0];
      res_data.total_angle_q8 <= total[TOTAL_W-1:0];
    end
  end

endmodule

>>> rtl/core/mft_out_fifo.sv
`timescale 1ns / 1ps

module mft_out_fifo import mft_pkg::*; (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  mft_result_t                         push_data,
  input  logic                                pop,
  output logic                                valid,
  output mft_result_t                         data,
  output logic [$clog2(FIFO_DEPTH+1)-1:0]     level
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int LW = $clog2(FIFO_DEPTH + 1);

  mft_result_t    mem [FIFO_DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic           do_pop;

  assign valid  = (level != '0);
  assign data   = mem[rptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= rptr + PW'(1);
      end
      level <= level + LW'(push) - LW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

endmodule

>>> rtl/core/motor_feedback_multiturn_tracker.sv
`timescale 1ns / 1ps
// Path: each frame is registered through update stages s1 and upd, scale stages b, c, d and
// res, and the output buffer. Throughput: one frame per cycle while ready is high; the
// per-slot read-modify-write of the state RAM closes through a one-entry bypass. Up to 8
// frames are in flight, bounded by the output buffer; ready drops only when all 8 are taken.
// Reset: mask cleared, all slots read as zero (per-slot valid bits), in-flight frames dropped.

module motor_feedback_multiturn_tracker import mft_pkg::*; #(
  parameter int SLOT_COUNT = 8,
  parameter int TURN_BITS  = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [MASK_W-1:0] cfg_wdata,
  mft_fb_if.sink            feedback,
  mft_res_if.source         result
);

  localparam int LW = $clog2(FIFO_DEPTH + 1);

  logic [MASK_W-1:0] no_temp_slot_mask;
  logic [LW-1:0]     cnt;
  logic [LW-1:0]     fifo_level;
  logic              accept;
  logic              pop;

  logic                        upd_valid;
  mft_item_t                   upd_item;
  logic signed [TURN_BITS-1:0] upd_turns;
  logic                        res_valid;
  mft_result_t                 res_data;
  mft_result_t                 out_data;

  assign accept         = feedback.valid && feedback.ready;
  assign pop            = result.valid && result.ready;
  assign feedback.ready = (cnt < LW'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      no_temp_slot_mask <= '0;
      cnt               <= '0;
    end else begin
      if (cfg_we) begin
        no_temp_slot_mask <= cfg_wdata;
      end
      cnt <= cnt + LW'(accept) - LW'(pop);
    end
  end

  mft_update #(
    .SLOT_COUNT (SLOT_COUNT),
    .TURN_BITS  (TURN_BITS)
  ) u_update (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .frame_id          (feedback.frame_id),
    .angle_word        (feedback.angle_word),
    .speed_word        (feedback.speed_word),
    .torque_word       (feedback.torque_word),
    .temp_byte         (feedback.temp_byte),
    .no_temp_slot_mask (no_temp_slot_mask),
    .upd_valid         (upd_valid),
    .upd_item          (upd_item),
    .upd_turns         (upd_turns)
  );

  mft_scale #(
    .TURN_BITS (TURN_BITS)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .upd_valid (upd_valid),
    .upd_item  (upd_item),
    .upd_turns (upd_turns),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  mft_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res_data),
    .pop       (result.ready),
    .valid     (result.valid),
    .data      (out_data),
    .level     (fifo_level)
  );

  assign result.id_error       = out_data.id_error;
  assign result.slot_index     = out_data.slot_index;
  assign result.raw_angle      = out_data.raw_angle;
  assign result.speed_value    = out_data.speed_value;
  assign result.torque_value   = out_data.torque_value;
  assign result.temperature    = out_data.temperature;
  assign result.turn_count     = out_data.turn_count;
  assign result.total_angle_q8 = out_data.total_angle_q8;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= LW'(FIFO_DEPTH))
    else $error("in-flight count above buffer depth");

  a_fifo_credit: assert property (@(posedge clk) disable iff (rst)
    fifo_level <= cnt)
    else $error("output buffer holds more than was accepted");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (fifo_level < LW'(FIFO_DEPTH)))
    else $error("result pushed into full output buffer");

endmodule

>>> tb/motor_feedback_multiturn_tracker_tb.sv
`timescale 1ns / 1ps

module motor_feedback_multiturn_tracker_tb;
  import mft_pkg::*;

  localparam int SLOTS      = 8;
  localparam int TURN_LIM   = 24;
  localparam int LATENCY    = 6;
  localparam int IDLE_LIMIT = 2000;
  localparam longint TURN_MAX = (64'sd1 <<< (TURN_LIM - 1)) - 1;
  localparam longint TURN_MIN = -TURN_MAX - 1;

  typedef struct {
    logic [ID_W-1:0]          id;
    logic [ANG_W-1:0]         ang;
    logic signed [SPD_W-1:0]  spd;
    logic signed [TRQ_W-1:0]  trq;
    logic signed [TEMP_W-1:0] tmp;
  } frame_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [MASK_W-1:0] cfg_wdata;

  mft_fb_if  fb ();
  mft_res_if res ();

  motor_feedback_multiturn_tracker uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .feedback  (fb),
    .result    (res)
  );

  frame_t      frame_queue[$];
  mft_result_t tracked_results[$];

  // tracker state as the testbench sees it
  logic [ANG_W-1:0]         prev_raw[SLOTS];
  logic signed [TURN_LIM-1:0] turn_mem[SLOTS];
  logic [TEMP_W-1:0]        temp_mem[SLOTS];
  logic [MASK_W-1:0]        keep_temp_mask;

  int mismatch_count;
  int src_gap, src_calm, snk_gap, snk_calm;
  int idle_cycles;

  // generator cursors for well-formed rotation
  int cursor[1:SLOTS];
  int spin[1:SLOTS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic in_top_quarter(longint a);
    return a >= longint'(TOP_LOW) && a <= longint'(RAW_FULL);
  endfunction

  function automatic logic in_bottom_quarter(longint a);
    return a >= longint'(BOTTOM_LOW) && a <= longint'(BOTTOM_HIGH);
  endfunction

  function automatic mft_result_t track_frame(frame_t f);
    mft_result_t r;
    int          slot;
    int          k;
    longint      prev;
    longint      raw;
    longint      turns;
    longint      total;
    r = '0;
    slot = int'(f.id) - int'(SLOT_BASE);
    if (slot < 1 || slot > SLOTS) begin
      r.id_error = 1'b1;
      return r;
    end
    k = slot - 1;
    prev = longint'($signed(prev_raw[k]));
    raw = longint'($signed(f.ang));
    turns = longint'(turn_mem[k]);
    if (in_top_quarter(prev) && in_bottom_quarter(raw)) begin
      if (turns < TURN_MAX) turns++;
    end else if (in_bottom_quarter(prev) && in_top_quarter(raw)) begin
      if (turns > TURN_MIN) turns--;
    end
    turn_mem[k] = turns[TURN_LIM-1:0];
    prev_raw[k] = f.ang;
    if (!keep_temp_mask[k]) temp_mem[k] = f.tmp;
    total = turns * longint'(Q8_PER_TURN) + (raw * longint'(Q8_PER_TURN)) / longint'(RAW_FULL);
    r.slot_index     = slot[SLOT_W-1:0];
    r.raw_angle      = f.ang;
    r.speed_value    = f.spd;
    r.torque_value   = f.trq;
    r.temperature    = temp_mem[k];
    r.turn_count     = turns[TURN_OUT_W-1:0];
    r.total_angle_q8 = total[TOTAL_W-1:0];
    return r;
  endfunction

  // mostly back-to-back, some short gaps, a few long ones, with calm stretches
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 199) == 0) calm = $urandom_range(30, 80);
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 9);
    return $urandom_range(20, 60);
  endfunction

  task automatic field_mismatch(string name, logic [63:0] want, logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s: expected 0x%0h got 0x%0h", name, want, got);
  endtask

  task automatic check_result();
    mft_result_t want;
    if (tracked_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result transfer: slot %0d", res.slot_index);
      return;
    end
    want = tracked_results.pop_front();
    if (res.id_error !== want.id_error)
      field_mismatch("id_error", want.id_error, res.id_error);
    if (res.slot_index !== want.slot_index)
      field_mismatch("slot_index", want.slot_index, res.slot_index);
    if (res.raw_angle !== want.raw_angle)
      field_mismatch("raw_angle", want.raw_angle, res.raw_angle);
    if (res.speed_value !== want.speed_value)
      field_mismatch("speed_value", want.speed_value, res.speed_value);
    if (res.torque_value !== want.torque_value)
      field_mismatch("torque_value", want.torque_value, res.torque_value);
    if (res.temperature !== want.temperature)
      field_mismatch("temperature", want.temperature, res.temperature);
    if (res.turn_count !== want.turn_count)
      field_mismatch("turn_count", want.turn_count, res.turn_count);
    if (res.total_angle_q8 !== want.total_angle_q8)
      field_mismatch("total_angle_q8", want.total_angle_q8, res.total_angle_q8);
  endtask

  // feedback driver
  always @(posedge clk) begin : feedback_driver
    frame_t f;
    if (rst) begin
      fb.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (fb.valid && fb.ready) begin
        f.id  = fb.frame_id;
        f.ang = fb.angle_word;
        f.spd = fb.speed_word;
        f.trq = fb.torque_word;
        f.tmp = fb.temp_byte;
        tracked_results.push_back(track_frame(f));
      end
      if (!fb.valid || fb.ready) begin
        if (src_gap > 0) begin
          fb.valid <= 1'b0;
          src_gap--;
        end else if (frame_queue.size() > 0) begin
          f = frame_queue.pop_front();
          fb.frame_id    <= f.id;
          fb.angle_word  <= f.ang;
          fb.speed_word  <= f.spd;
          fb.torque_word <= f.trq;
          fb.temp_byte   <= f.tmp;
          fb.valid       <= 1'b1;
          src_gap = pick_gap(src_calm);
        end else begin
          fb.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (res.valid && res.ready) check_result();
      if (snk_gap > 0) begin
        res.ready <= 1'b0;
        snk_gap--;
      end else begin
        res.ready <= 1'b1;
        snk_gap = pick_gap(snk_calm);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (fb.valid && fb.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_frame(int id, int ang, int spd, int trq, int tmp);
    frame_t f;
    f.id  = id[ID_W-1:0];
    f.ang = ang[ANG_W-1:0];
    f.spd = spd[SPD_W-1:0];
    f.trq = trq[TRQ_W-1:0];
    f.tmp = tmp[TEMP_W-1:0];
    frame_queue.push_back(f);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (frame_queue.size() != 0 || fb.valid || tracked_results.size() != 0);
  endtask

  task automatic write_mask(logic [MASK_W-1:0] value);
    wait_drained();
    repeat (LATENCY + 2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    keep_temp_mask = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_random(int count);
    int pick;
    int slot;
    int step;
    int ang;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      slot = $urandom_range(1, SLOTS);
      if (pick < 4) begin
        queue_frame($urandom_range(0, 2047), $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 8) begin
        queue_frame($urandom_range(int'(SLOT_BASE) - 8, int'(SLOT_BASE) + 15),
                    $urandom, $urandom, $urandom, $urandom);
      end else begin
        if (pick < 14) begin
          ang = $urandom;
        end else begin
          if ($urandom_range(0, 49) == 0) spin[slot] = -spin[slot];
          step = $urandom_range(0, 2600);
          if ($urandom_range(0, 4) == 0) step = -step;
          cursor[slot] = (cursor[slot] + spin[slot] * step) & 8191;
          ang = cursor[slot];
        end
        queue_frame(int'(SLOT_BASE) + slot, ang, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    fb.valid       = 1'b0;
    fb.frame_id    = '0;
    fb.angle_word  = '0;
    fb.speed_word  = '0;
    fb.torque_word = '0;
    fb.temp_byte   = '0;
    res.ready      = 1'b0;
    mismatch_count = 0;
    src_calm       = 0;
    snk_calm       = 0;
    idle_cycles    = 0;
    keep_temp_mask = '0;
    for (int i = 0; i < SLOTS; i++) begin
      prev_raw[i]   = '0;
      turn_mem[i]   = '0;
      temp_mem[i]   = '0;
      cursor[i + 1] = 0;
      spin[i + 1]   = (i % 2 == 0) ? 1 : -1;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    write_mask(8'h5A);
    // bad identifiers
    queue_frame(0, 16'hFFFF, 32767, -32768, 127);
    queue_frame(int'(SLOT_BASE), 100, 1, 1, 1);
    queue_frame(int'(SLOT_BASE) + 9, 100, 1, 1, 1);
    queue_frame(2047, 16'hFFFF, -1, -1, -1);
    // slot 1 wraps across the quarter boundaries
    queue_frame(int'(SLOT_BASE) + 1, 8191, -32768, 32767, -128);
    queue_frame(int'(SLOT_BASE) + 1, 0, 0, 0, 0);
    queue_frame(int'(SLOT_BASE) + 1, 8191, 5, -5, 20);
    queue_frame(int'(SLOT_BASE) + 1, 2047, 32767, -32768, 127);
    queue_frame(int'(SLOT_BASE) + 1, 6144, -1, 1, -1);
    queue_frame(int'(SLOT_BASE) + 1, 2048, 100, 200, 30);
    queue_frame(int'(SLOT_BASE) + 1, 6143, 100, 200, 31);
    // slot 2 keeps its temperature; negative turns and out-of-range angles
    queue_frame(int'(SLOT_BASE) + 2, 0, 7, 7, 55);
    queue_frame(int'(SLOT_BASE) + 2, 8000, 7, 7, 56);
    queue_frame(int'(SLOT_BASE) + 2, 16'hFFFF, 7, 7, 57);
    queue_frame(int'(SLOT_BASE) + 2, 16'h8000, 7, 7, 58);
    queue_frame(int'(SLOT_BASE) + 2, 16'h7FFF, 7, 7, 59);
    queue_frame(int'(SLOT_BASE) + 2, 8192, 7, 7, 60);
    for (int s = 3; s <= SLOTS; s++)
      queue_frame(int'(SLOT_BASE) + s, 4096, s * 1000, -s * 1000, s * 10 - 64);
    queue_frame(int'(SLOT_BASE) + 8, 7000, 1, 2, 3);
    queue_frame(int'(SLOT_BASE) + 8, 100, 1, 2, -3);

    write_mask(8'hFF);
    queue_random(256);
    write_mask(8'h00);
    queue_random(256);
    write_mask(MASK_W'($urandom));
    queue_random(256);
    write_mask(MASK_W'($urandom));
    queue_random(256);

    wait_drained();
    repeat (LATENCY * 4) @(posedge clk);
    if (mismatch_count == 0 && tracked_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
